/* hw/rtl/rscs_pkg.sv */
// ----------------------------------------------------------------------------
// rscs_pkg
// Shared widths, limits, register indexes and result types of the
// range scan cluster segmenter.
// ----------------------------------------------------------------------------
package rscs_pkg;

	localparam int RANGE_W        = 16;
	localparam int IDX_W          = 11;
	localparam int CNT_W          = 12;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int MAX_POINTS     = 2048;
	localparam int WARMUP_SAMPLES = 2;

	localparam logic [CNT_W-1:0] CNT_LIMIT =
		CNT_W'((MAX_POINTS < 4095) ? MAX_POINTS : 4095);

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MM        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_MM  = 2'd3;

	localparam logic                 RST_FILTER_ENABLE = 1'b1;
	localparam logic [RANGE_W-1:0]   RST_GAP_MM        = 16'd50;
	localparam logic [CNT_W-1:0]     RST_MIN_POINTS    = 12'd3;
	localparam logic [RANGE_W-1:0]   RST_MAX_RANGE_MM  = 16'd4000;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [IDX_W-1:0] seg_low_index;
		logic [IDX_W-1:0] seg_high_index;
		logic [CNT_W-1:0] point_count;
		logic [CNT_W-1:0] cluster_number;
		logic             last_of_run;
	} seg_result_t;

	typedef struct packed {
		logic a_valid;
		logic b_valid;
	} push_ctl_t;

endpackage

/* hw/rtl/rscs_result_queue.sv */
// ----------------------------------------------------------------------------
// rscs_result_queue
// Small result queue: takes up to two beats per cycle, hands out one.
// ----------------------------------------------------------------------------
module rscs_result_queue
	import rscs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  push_ctl_t            push,
	input  seg_result_t          push_a,
	input  seg_result_t          push_b,
	input  logic                 pop,
	output seg_result_t          head,
	output logic [Q_CNT_W-1:0]   count
);

	seg_result_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic [Q_CNT_W-1:0]   n_push;
	logic [Q_PTR_W-1:0]   wr_ptr_b;

	assign n_push   = Q_CNT_W'(push.a_valid) + Q_CNT_W'(push.b_valid);
	assign wr_ptr_b = wr_ptr_q + Q_PTR_W'(1);
	assign head     = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push.a_valid) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push.b_valid) begin
			mem_q[wr_ptr_b] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + n_push - Q_CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue overflow");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.b_valid |-> push.a_valid)
		else $error("second beat pushed without first");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push.a_valid) |=> count_q == $past(count_q) - Q_CNT_W'(1))
		else $error("pop did not drain one beat");

endmodule

/* hw/rtl/range_scan_cluster_segmenter.sv */
// ----------------------------------------------------------------------------
// range_scan_cluster_segmenter
// Laser scan range-jump segmentation: filters, clusters and reports segments.
// ----------------------------------------------------------------------------
// Result beats are written to the result queue and offered from its head.
// Throughput: one sample per cycle; a sample may push two result beats, and
// the four-entry result queue stalls input when fewer than two slots are free.
// Reset: asynchronous, clears running state and loads register defaults.
// ----------------------------------------------------------------------------
module range_scan_cluster_segmenter
	import rscs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [RANGE_W-1:0]      range_mm,
	input  logic [IDX_W-1:0]        sample_index,
	input  logic                    start_of_scan,
	input  logic                    end_of_scan,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [IDX_W-1:0]        seg_low_index,
	output logic [IDX_W-1:0]        seg_high_index,
	output logic [CNT_W-1:0]        point_count,
	output logic [CNT_W-1:0]        cluster_number,
	output logic                    last_of_run
);

	logic                 filter_enable_q;
	logic [RANGE_W-1:0]   gap_mm_q;
	logic [CNT_W-1:0]     min_points_q;
	logic [RANGE_W-1:0]   max_range_mm_q;

	logic [RANGE_W-1:0]   prev_raw_q;
	logic [RANGE_W-1:0]   prev_filt_q;
	logic                 cluster_open_q;
	logic [IDX_W-1:0]     cluster_top_q;
	logic [CNT_W-1:0]     run_count_q;
	logic [CNT_W-1:0]     valid_total_q;
	logic [1:0]           scan_pos_q;

	logic                 accept;
	logic [RANGE_W-1:0]   pr;
	logic [RANGE_W-1:0]   pf;
	logic                 open0;
	logic [IDX_W-1:0]     top0;
	logic [CNT_W-1:0]     cnt0;
	logic [CNT_W-1:0]     vt0;
	logic [1:0]           pos0;
	logic [RANGE_W:0]     sum;
	logic [RANGE_W-1:0]   filt;
	logic [RANGE_W-1:0]   diff;
	logic                 beyond;
	logic                 join_c;
	logic                 emit1;
	logic [CNT_W-1:0]     vt1;
	logic                 open2;
	logic [IDX_W-1:0]     top2;
	logic [CNT_W-1:0]     cnt2;
	logic                 emit2;
	logic [CNT_W-1:0]     vt2;
	seg_result_t          res1;
	seg_result_t          res2;
	seg_result_t          push_a;
	seg_result_t          push_b;
	push_ctl_t            push;
	seg_result_t          head;
	logic [Q_CNT_W-1:0]   q_count;
	logic                 pop;

	assign in_stall = q_count > Q_CNT_W'(Q_DEPTH - 2);
	assign accept   = in_valid && !in_stall;
	assign out_valid = q_count != '0;
	assign pop      = out_valid && !out_stall;

	always_comb begin
		pr    = start_of_scan ? '0 : prev_raw_q;
		pf    = start_of_scan ? '0 : prev_filt_q;
		open0 = start_of_scan ? 1'b0 : cluster_open_q;
		top0  = start_of_scan ? '0 : cluster_top_q;
		cnt0  = start_of_scan ? '0 : run_count_q;
		vt0   = start_of_scan ? '0 : valid_total_q;
		pos0  = start_of_scan ? '0 : scan_pos_q;

		sum  = {1'b0, range_mm} + {1'b0, pr};
		filt = (filter_enable_q && (pos0 >= 2'(WARMUP_SAMPLES))) ? sum[RANGE_W:1] : range_mm;
		diff = (filt >= pf) ? (filt - pf) : (pf - filt);
		beyond = filt > max_range_mm_q;
		join_c = !beyond && open0 && (diff < gap_mm_q);

		emit1 = !join_c && open0 && (cnt0 >= min_points_q) && (cnt0 != '0);
		vt1   = (emit1 && (vt0 < CNT_LIMIT)) ? vt0 + CNT_W'(1) : vt0;
		res1.seg_low_index  = top0 - IDX_W'(cnt0 - CNT_W'(1));
		res1.seg_high_index = top0;
		res1.point_count    = cnt0;
		res1.cluster_number = vt1;
		res1.last_of_run    = 1'b0;

		if (beyond) begin
			open2 = 1'b0;
			top2  = top0;
			cnt2  = '0;
		end else if (join_c) begin
			open2 = 1'b1;
			top2  = top0;
			cnt2  = (cnt0 < CNT_LIMIT) ? cnt0 + CNT_W'(1) : cnt0;
		end else begin
			open2 = 1'b1;
			top2  = sample_index;
			cnt2  = CNT_W'(1);
		end

		emit2 = end_of_scan && open2 && (cnt2 >= min_points_q) && (cnt2 != '0);
		vt2   = (emit2 && (vt1 < CNT_LIMIT)) ? vt1 + CNT_W'(1) : vt1;
		res2.seg_low_index  = top2 - IDX_W'(cnt2 - CNT_W'(1));
		res2.seg_high_index = top2;
		res2.point_count    = cnt2;
		res2.cluster_number = vt2;
		res2.last_of_run    = 1'b1;

		push_a = emit1 ? res1 : res2;
		push_a.last_of_run = !(emit1 && emit2);
		push_b = res2;
		push.a_valid = accept && (emit1 || emit2);
		push.b_valid = accept && emit1 && emit2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= RST_FILTER_ENABLE;
			gap_mm_q        <= RST_GAP_MM;
			min_points_q    <= RST_MIN_POINTS;
			max_range_mm_q  <= RST_MAX_RANGE_MM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				REG_GAP_MM:        gap_mm_q        <= cfg_data;
				REG_MIN_POINTS:    min_points_q    <= cfg_data[CNT_W-1:0];
				REG_MAX_RANGE_MM:  max_range_mm_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q     <= '0;
			prev_filt_q    <= '0;
			cluster_open_q <= 1'b0;
			cluster_top_q  <= '0;
			run_count_q    <= '0;
			valid_total_q  <= '0;
			scan_pos_q     <= '0;
		end else if (accept) begin
			prev_raw_q     <= range_mm;
			prev_filt_q    <= filt;
			cluster_open_q <= open2 && !end_of_scan;
			cluster_top_q  <= top2;
			run_count_q    <= end_of_scan ? '0 : cnt2;
			valid_total_q  <= vt2;
			scan_pos_q     <= (pos0 < 2'd2) ? pos0 + 2'd1 : pos0;
		end
	end

	rscs_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_a (push_a),
		.push_b (push_b),
		.pop    (pop),
		.head   (head),
		.count  (q_count)
	);

	assign seg_low_index  = head.seg_low_index;
	assign seg_high_index = head.seg_high_index;
	assign point_count    = head.point_count;
	assign cluster_number = head.cluster_number;
	assign last_of_run    = head.last_of_run;

	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		cluster_open_q == (run_count_q != '0))
		else $error("open flag and run count disagree");

	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		scan_pos_q != 2'd3)
		else $error("scan position past saturation");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_count != '0)
		else $error("empty cluster reported");

endmodule

/* tb/sv/range_scan_cluster_segmenter_chk.sv */
// ----------------------------------------------------------------------------
// range_scan_cluster_segmenter_chk
// Watches the sample, segment and register ports of the segmenter. Keeps its
// own copy of the settings and the scan state, works out the segments that
// each accepted sample closes, and compares every segment beat with the oldest
// outstanding prediction. Mismatches are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module range_scan_cluster_segmenter_chk
	import rscs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [RANGE_W-1:0]    range_mm,
	input  logic [IDX_W-1:0]      sample_index,
	input  logic                  start_of_scan,
	input  logic                  end_of_scan,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [IDX_W-1:0]      seg_low_index,
	input  logic [IDX_W-1:0]      seg_high_index,
	input  logic [CNT_W-1:0]      point_count,
	input  logic [CNT_W-1:0]      cluster_number,
	input  logic                  last_of_run,
	output logic [31:0]           fail_total,
	output logic [31:0]           expect_depth
);

	logic               cf_filter;
	logic [RANGE_W-1:0] cf_gap;
	logic [CNT_W-1:0]   cf_min;
	logic [RANGE_W-1:0] cf_max;

	logic [RANGE_W-1:0] last_raw;
	logic [RANGE_W-1:0] last_filt;
	logic               seg_open;
	logic [IDX_W-1:0]   seg_top;
	logic [CNT_W-1:0]   seg_pts;
	logic [CNT_W-1:0]   seg_ord;
	logic [1:0]         scan_pos;

	seg_result_t        segments_due[$];
	seg_result_t        step_segments[$];

	task automatic clear_scan();
		last_raw  = '0;
		last_filt = '0;
		seg_open  = 1'b0;
		seg_top   = '0;
		seg_pts   = '0;
		seg_ord   = '0;
		scan_pos  = '0;
	endtask

	task automatic close_segment();
		seg_result_t seg;
		if (seg_open && seg_pts >= cf_min && seg_pts >= 1) begin
			if (seg_ord < CNT_LIMIT)
				seg_ord = seg_ord + 1'b1;
			seg.seg_low_index  = seg_top - IDX_W'(seg_pts - 1'b1);
			seg.seg_high_index = seg_top;
			seg.point_count    = seg_pts;
			seg.cluster_number = seg_ord;
			seg.last_of_run    = 1'b0;
			step_segments.insert(step_segments.size(), seg);
		end
		seg_open = 1'b0;
		seg_pts  = '0;
	endtask

	task automatic predict_segments(input logic [RANGE_W-1:0] raw, input logic [IDX_W-1:0] idx,
			input logic sos, input logic eos);
		logic [RANGE_W:0]   sum;
		logic [RANGE_W-1:0] filt;
		logic [RANGE_W-1:0] diff;
		seg_result_t        seg;
		int                 last_k;
		step_segments.delete();
		if (sos)
			clear_scan();
		sum  = {1'b0, raw} + {1'b0, last_raw};
		filt = (cf_filter && scan_pos >= 2) ? sum[RANGE_W:1] : raw;
		if (filt > cf_max) begin
			close_segment();
		end else begin
			diff = (filt >= last_filt) ? filt - last_filt : last_filt - filt;
			if (seg_open && diff < cf_gap) begin
				if (seg_pts < CNT_LIMIT)
					seg_pts = seg_pts + 1'b1;
			end else begin
				close_segment();
				seg_open = 1'b1;
				seg_top  = idx;
				seg_pts  = CNT_W'(1);
			end
		end
		last_raw  = raw;
		last_filt = filt;
		if (scan_pos < 2)
			scan_pos = scan_pos + 1'b1;
		if (eos)
			close_segment();
		if (step_segments.size() > 0) begin
			last_k = step_segments.size() - 1;
			seg = step_segments[last_k];
			seg.last_of_run = 1'b1;
			step_segments[last_k] = seg;
		end
		foreach (step_segments[k])
			segments_due.insert(segments_due.size(), step_segments[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_proc
		seg_result_t got;
		seg_result_t want;
		if (!arst_n) begin
			cf_filter = RST_FILTER_ENABLE;
			cf_gap    = RST_GAP_MM;
			cf_min    = RST_MIN_POINTS;
			cf_max    = RST_MAX_RANGE_MM;
			clear_scan();
			segments_due.delete();
			fail_total   = 0;
			expect_depth = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.seg_low_index  = seg_low_index;
				got.seg_high_index = seg_high_index;
				got.point_count    = point_count;
				got.cluster_number = cluster_number;
				got.last_of_run    = last_of_run;
				if (segments_due.size() == 0) begin
					$display("%0t: segment beat with none expected: low=%0d high=%0d pts=%0d num=%0d last=%0d",
						$time, got.seg_low_index, got.seg_high_index, got.point_count,
						got.cluster_number, got.last_of_run);
					fail_total = fail_total + 1;
				end else begin
					want = segments_due.pop_front();
					if (got !== want) begin
						$display("%0t: expected low=%0d high=%0d pts=%0d num=%0d last=%0d",
							$time, want.seg_low_index, want.seg_high_index, want.point_count,
							want.cluster_number, want.last_of_run);
						$display("%0t: actual   low=%0d high=%0d pts=%0d num=%0d last=%0d",
							$time, got.seg_low_index, got.seg_high_index, got.point_count,
							got.cluster_number, got.last_of_run);
						fail_total = fail_total + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_ENABLE: cf_filter = cfg_data[0];
					REG_GAP_MM:        cf_gap    = cfg_data[RANGE_W-1:0];
					REG_MIN_POINTS:    cf_min    = cfg_data[CNT_W-1:0];
					REG_MAX_RANGE_MM:  cf_max    = cfg_data[RANGE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_segments(range_mm, sample_index, start_of_scan, end_of_scan);
			expect_depth = segments_due.size();
		end
	end

endmodule

/* tb/sv/range_scan_cluster_segmenter_tb.sv */
// ----------------------------------------------------------------------------
// range_scan_cluster_segmenter_tb
// Drives range samples and register writes into the segmenter and gives the
// verdict. A short directed sequence covers filter start-up, no-return values,
// scan restarts and double segment beats; random phases then sweep the
// settings with well-formed and broken scans, random idling on both sides,
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
module range_scan_cluster_segmenter_tb;
	import rscs_pkg::*;

	localparam int IDLE_PCT     = 22;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 4;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 1790;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_stall;
	logic [RANGE_W-1:0]    range_mm      = '0;
	logic [IDX_W-1:0]      sample_index  = '0;
	logic                  start_of_scan = 1'b0;
	logic                  end_of_scan   = 1'b0;
	logic                  out_valid;
	logic                  out_stall     = 1'b0;
	logic [IDX_W-1:0]      seg_low_index;
	logic [IDX_W-1:0]      seg_high_index;
	logic [CNT_W-1:0]      point_count;
	logic [CNT_W-1:0]      cluster_number;
	logic                  last_of_run;
	logic [31:0]           fail_total;
	logic [31:0]           expect_depth;

	bit                    tx_idle     = 1'b1;
	bit                    rx_idle     = 1'b1;
	int unsigned           hold_req    = 0;
	int unsigned           hold_ack    = 0;
	int unsigned           samples_out = 0;
	int unsigned           quiet_cycles = 0;

	always #6 clk = ~clk;

	range_scan_cluster_segmenter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.range_mm       (range_mm),
		.sample_index   (sample_index),
		.start_of_scan  (start_of_scan),
		.end_of_scan    (end_of_scan),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.seg_low_index  (seg_low_index),
		.seg_high_index (seg_high_index),
		.point_count    (point_count),
		.cluster_number (cluster_number),
		.last_of_run    (last_of_run)
	);

	range_scan_cluster_segmenter_chk i_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.range_mm       (range_mm),
		.sample_index   (sample_index),
		.start_of_scan  (start_of_scan),
		.end_of_scan    (end_of_scan),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.seg_low_index  (seg_low_index),
		.seg_high_index (seg_high_index),
		.point_count    (point_count),
		.cluster_number (cluster_number),
		.last_of_run    (last_of_run),
		.fail_total     (fail_total),
		.expect_depth   (expect_depth)
	);

	task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic [IDX_W-1:0] idx,
			input logic sos, input logic eos);
		while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		range_mm      <= rng;
		sample_index  <= idx;
		start_of_scan <= sos;
		end_of_scan   <= eos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		samples_out++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expect_depth != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic fe, input logic [RANGE_W-1:0] gap,
			input logic [CNT_W-1:0] minp, input logic [RANGE_W-1:0] maxr);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FILTER_ENABLE;
		cfg_data  <= CFG_DATA_W'(fe);
		@(posedge clk);
		cfg_index <= REG_GAP_MM;
		cfg_data  <= gap;
		@(posedge clk);
		cfg_index <= REG_MIN_POINTS;
		cfg_data  <= CFG_DATA_W'(minp);
		@(posedge clk);
		cfg_index <= REG_MAX_RANGE_MM;
		cfg_data  <= maxr;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_scan(input int unsigned len, input bit tidy);
		logic [RANGE_W-1:0] level;
		logic [RANGE_W-1:0] rng;
		logic [IDX_W-1:0]   idx;
		logic               sos;
		logic               eos;
		int unsigned        roll;
		level = RANGE_W'($urandom_range(6000));
		idx   = IDX_W'($urandom_range(2047));
		for (int unsigned k = 0; k < len; k++) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				rng = '1;
			end else if (roll < 9) begin
				rng = RANGE_W'($urandom_range(65535));
			end else begin
				if (roll < 17)
					level = RANGE_W'($urandom_range(6000));
				else
					level = level + RANGE_W'($urandom_range(60)) - RANGE_W'(30);
				rng = level;
			end
			if (tidy) begin
				sos = (k == 0);
				eos = (k == len - 1);
			end else begin
				sos = ($urandom_range(9) == 0);
				eos = ($urandom_range(9) == 0);
				idx = IDX_W'($urandom_range(2047));
			end
			send_sample(rng, idx, sos, eos);
			idx = idx - 1'b1;
		end
	endtask

	initial begin : rx_proc
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= rx_idle && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stim_proc
		int unsigned phase;
		int unsigned random_start;
		logic        fe;
		logic [RANGE_W-1:0] gap;
		logic [CNT_W-1:0]   minp;
		logic [RANGE_W-1:0] maxr;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: filter start-up, no-return, restart over an open segment
		send_sample(16'd1000,  11'd2047, 1'b1, 1'b0);
		send_sample(16'd1010,  11'd2046, 1'b0, 1'b0);
		send_sample(16'd1020,  11'd2045, 1'b0, 1'b0);
		send_sample(16'd1030,  11'd2044, 1'b0, 1'b0);
		send_sample(16'hFFFF,  11'd2043, 1'b0, 1'b0);
		send_sample(16'hFFFF,  11'd2042, 1'b0, 1'b0);
		send_sample(16'd3000,  11'd2041, 1'b0, 1'b0);
		send_sample(16'd3000,  11'd2040, 1'b0, 1'b0);
		send_sample(16'd3010,  11'd2039, 1'b0, 1'b0);
		send_sample(16'd3020,  11'd2038, 1'b0, 1'b0);
		send_sample(16'd0,     11'd1,    1'b1, 1'b0);
		send_sample(16'd0,     11'd0,    1'b0, 1'b0);
		send_sample(16'd40,    11'd2047, 1'b0, 1'b1);
		drain();

		// zero gap, zero min points: one segment per sample, two beats when end of scan meets an open segment
		set_config(1'b0, 16'd0, 12'd0, 16'hFFFF);
		send_sample(16'hFFFF,  11'd0,    1'b1, 1'b0);
		send_sample(16'hFFFF,  11'd1,    1'b0, 1'b0);
		send_sample(16'd5,     11'd2,    1'b0, 1'b1);
		send_sample(16'd7,     11'd3,    1'b0, 1'b0);
		send_sample(16'd9,     11'd4,    1'b1, 1'b0);
		send_sample(16'd9,     11'd5,    1'b1, 1'b1);
		send_sample(16'hAAAA,  11'h555,  1'b0, 1'b1);
		send_sample(16'h5555,  11'h2AA,  1'b0, 1'b1);
		drain();

		phase        = 0;
		random_start = samples_out;
		while (samples_out - random_start < RANDOM_ITEMS) begin
			tx_idle = 1'b1;
			rx_idle = 1'b1;
			fe   = 1'($urandom_range(1));
			gap  = ($urandom_range(99) < 70) ? RANGE_W'($urandom_range(120, 10))
			                                 : RANGE_W'($urandom_range(65535));
			minp = CNT_W'($urandom_range(6));
			maxr = ($urandom_range(99) < 70) ? RANGE_W'($urandom_range(8000, 3000))
			                                 : RANGE_W'($urandom_range(65535));
			case (phase)
				0: set_config(RST_FILTER_ENABLE, RST_GAP_MM, RST_MIN_POINTS, RST_MAX_RANGE_MM);
				1: begin
					set_config(1'b0, 16'd0, 12'd1, 16'hFFFF);
					tx_idle = 1'b0;
					hold_req++;
				end
				2: set_config(1'b1, 16'hFFFF, 12'hFFF, 16'd0);
				3: set_config(1'b0, 16'hFFFF, 12'd0, 16'hFFFF);
				4: begin
					set_config(fe, gap, minp, maxr);
					tx_idle = 1'b0;
					rx_idle = 1'b0;
				end
				default: set_config(fe, gap, minp, maxr);
			endcase
			for (int s = 0; s < 8; s++)
				run_scan($urandom_range(40, 3), $urandom_range(99) < 85);
			drain();
			phase++;
		end

		if (fail_total == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/rscs_pkg.sv
hw/rtl/rscs_result_queue.sv
hw/rtl/range_scan_cluster_segmenter.sv
tb/sv/range_scan_cluster_segmenter_chk.sv
tb/sv/range_scan_cluster_segmenter_tb.sv
